/* rtl/glcn_pkg.sv */
`timescale 1ns / 1ps
package glcn_pkg;
	localparam int MaxRowsDefault = 32;
	localparam int ValueW = 16;
	localparam int ScaleW = 16;
	localparam int GradW = 18;
	localparam int SumW = 36;
	localparam int TotalW = 40;
	localparam int PenW = 32;
	localparam int NormW = 18;

	typedef struct packed {
		logic signed [ValueW-1:0] weight_value;
		logic column_end;
		logic set_end;
	} glcn_in_t;

	typedef struct packed {
		logic signed [GradW-1:0] gradient;
		logic column_last;
		logic [PenW-1:0] penalty;
		logic penalty_valid;
		logic overflow;
	} glcn_out_t;
endpackage

/* rtl/group_lasso_column_norm_engine.sv */
`timescale 1ns / 1ps
// group lasso column norm engine: items accepted while busy is low
// a non-final element is captured and stored, then squared and accumulated
// a column end is also accumulated, then runs the square root, the total and the penalty;
// each gradient costs a read, a multiply, 32 restoring divide steps and a strobe
// results appear one per division on result_valid; the receiver cannot stall
// asynchronous active-low reset clears sums, counts and control; the store is not cleared
module group_lasso_column_norm_engine #(
	parameter int MAX_ROWS = glcn_pkg::MaxRowsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  glcn_pkg::glcn_in_t in_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [glcn_pkg::ScaleW-1:0] cfg_data,
	output logic result_valid,
	output glcn_pkg::glcn_out_t result
);
	import glcn_pkg::*;

	localparam int CntW = $clog2(MAX_ROWS + 1);
	localparam int IdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DivNW = ScaleW + ValueW; // scale * magnitude, 32 bits
	localparam int DivCntW = $clog2(DivNW + 1);
	localparam int SqCntW = $clog2(SumW / 2 + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_SQRT, ST_TOTAL, ST_PEN, ST_READ, ST_MUL, ST_DIV, ST_EMIT
	} state_t;

	state_t state_q;
	logic [ValueW-1:0] store_q [MAX_ROWS];
	logic [ValueW-1:0] rd_q;
	logic [ValueW-1:0] in_val_q;
	logic col_end_q, set_end_q;
	logic [CntW-1:0] row_count_q;
	logic [CntW-1:0] emit_idx_q;
	logic [SumW-1:0] square_sum_q;
	logic [TotalW-1:0] norm_total_q;
	logic dropped_q;
	logic [ScaleW-1:0] scale_q;
	logic [PenW-1:0] pen_q;
	// sequential square root and divider state, each with its own remainder register
	logic [SumW-1:0] sq_rad_q;
	logic [NormW+1:0] sq_rem_q;
	logic [NormW-1:0] norm_q;
	logic [SqCntW-1:0] sq_cnt_q;
	logic [DivNW-1:0] div_n_q;
	logic [NormW:0] div_rem_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic neg_q;
	logic [55:0] pen_prod_q;

	logic [ValueW-1:0] mag;
	logic [2*ValueW-1:0] sq;
	logic [SumW:0] sum_next;
	logic [NormW+1:0] sq_trial;
	logic [NormW+1:0] sq_rem_sh;
	logic [NormW:0] div_sh;
	logic [TotalW:0] tot_next;
	logic [ValueW-1:0] rd_mag;
	logic [GradW-1:0] grad;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		mag = in_val_q[ValueW-1] ? (~in_val_q + 1'b1) : in_val_q;
		sq = mag * mag;
		sum_next = {1'b0, square_sum_q} + {{(SumW+1-2*ValueW){1'b0}}, sq};
		sq_rem_sh = {sq_rem_q[NormW-1:0], sq_rad_q[SumW-1 -: 2]};
		sq_trial = {norm_q, 2'b01};
		div_sh = {div_rem_q[NormW-1:0], div_n_q[DivNW-1]};
		tot_next = {1'b0, norm_total_q} + {{(TotalW+1-NormW){1'b0}}, norm_q};
		rd_mag = rd_q[ValueW-1] ? (~rd_q + 1'b1) : rd_q;
		grad = neg_q ? (~div_n_q[GradW-1:0] + 1'b1) : div_n_q[GradW-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && row_count_q < CntW'(MAX_ROWS))
			store_q[row_count_q[IdxW-1:0]] <= in_item.weight_value;
		if (state_q == ST_READ)
			rd_q <= store_q[emit_idx_q[IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_count_q <= '0;
			square_sum_q <= '0;
			norm_total_q <= '0;
			dropped_q <= 1'b0;
			scale_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
			in_val_q <= '0;
			col_end_q <= 1'b0;
			set_end_q <= 1'b0;
			emit_idx_q <= '0;
			pen_q <= '0;
			sq_rad_q <= '0;
			sq_rem_q <= '0;
			norm_q <= '0;
			sq_cnt_q <= '0;
			div_n_q <= '0;
			div_rem_q <= '0;
			div_cnt_q <= '0;
			neg_q <= 1'b0;
			pen_prod_q <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid)
				scale_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						in_val_q <= in_item.weight_value;
						col_end_q <= in_item.column_end | in_item.set_end;
						set_end_q <= in_item.set_end;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (row_count_q < CntW'(MAX_ROWS)) begin
						row_count_q <= row_count_q + 1'b1;
						square_sum_q <= sum_next[SumW] ? '1 : sum_next[SumW-1:0];
					end else begin
						dropped_q <= 1'b1;
					end
					state_q <= col_end_q ? ST_SQRT : ST_IDLE;
					sq_rad_q <= (row_count_q < CntW'(MAX_ROWS))
						? (sum_next[SumW] ? '1 : sum_next[SumW-1:0]) : square_sum_q;
					sq_rem_q <= '0;
					norm_q <= '0;
					sq_cnt_q <= SqCntW'(SumW / 2);
				end
				ST_SQRT: begin
					// one result bit a cycle, two radicand bits shifted in
					sq_rad_q <= {sq_rad_q[SumW-3:0], 2'b00};
					if (sq_rem_sh >= sq_trial) begin
						sq_rem_q <= sq_rem_sh - sq_trial;
						norm_q <= {norm_q[NormW-2:0], 1'b1};
					end else begin
						sq_rem_q <= sq_rem_sh;
						norm_q <= {norm_q[NormW-2:0], 1'b0};
					end
					sq_cnt_q <= sq_cnt_q - 1'b1;
					if (sq_cnt_q == SqCntW'(1))
						state_q <= ST_TOTAL;
				end
				ST_TOTAL: begin
					norm_total_q <= tot_next[TotalW] ? '1 : tot_next[TotalW-1:0];
					emit_idx_q <= '0;
					state_q <= ST_PEN;
				end
				ST_PEN: begin
					pen_prod_q <= scale_q * norm_total_q;
					state_q <= ST_READ;
				end
				ST_READ: begin
					pen_q <= (|pen_prod_q[55:48]) ? '1 : pen_prod_q[47:16];
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					neg_q <= rd_q[ValueW-1];
					div_n_q <= scale_q * rd_mag;
					div_rem_q <= '0;
					div_cnt_q <= DivCntW'(DivNW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (div_sh >= {1'b0, norm_q}) begin
						div_rem_q <= div_sh - {1'b0, norm_q};
						div_n_q <= {div_n_q[DivNW-2:0], 1'b1};
					end else begin
						div_rem_q <= div_sh;
						div_n_q <= {div_n_q[DivNW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DivCntW'(1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					result_valid <= 1'b1;
					result.gradient <= (norm_q == '0) ? '0 : grad;
					result.overflow <= dropped_q;
					if (emit_idx_q + 1'b1 == row_count_q) begin
						result.column_last <= 1'b1;
						result.penalty <= set_end_q ? pen_q : '0;
						result.penalty_valid <= set_end_q;
						if (set_end_q)
							norm_total_q <= '0;
						row_count_q <= '0;
						square_sum_q <= '0;
						dropped_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						result.column_last <= 1'b0;
						result.penalty <= '0;
						result.penalty_valid <= 1'b0;
						emit_idx_q <= emit_idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import glcn_pkg::*;

	localparam int Rows = MaxRowsDefault;
	localparam logic [SumW-1:0] SumSat = {SumW{1'b1}};
	localparam logic [TotalW-1:0] TotalSat = {TotalW{1'b1}};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	glcn_in_t in_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [ScaleW-1:0] cfg_data;
	logic result_valid;
	glcn_out_t result;

	group_lasso_column_norm_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	// predictor state, mirrors the block's column buffer and sums
	logic [ValueW-1:0] col_buf [Rows];
	int unsigned col_rows;
	logic [SumW-1:0] col_sq_sum;
	logic [TotalW-1:0] run_total;
	logic col_dropped;
	logic [ScaleW-1:0] scale_reg;

	glcn_in_t pending_items[$];
	glcn_out_t expected_grads[$];
	int unsigned fail_count;
	int unsigned grads_seen;
	int unsigned penalties_seen;
	int unsigned items_sent;
	int unsigned gap_left;

	// append one element to the stimulus queue
	task automatic queue_item(input glcn_in_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// floor square root, digit by digit
	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// one accepted element: update state, queue gradients at column end
	task automatic predict_element(input glcn_in_t it);
		logic [63:0] mag;
		logic [63:0] sum;
		logic [63:0] nrm;
		logic [63:0] tot;
		logic [63:0] q;
		logic [63:0] pen;
		glcn_out_t r;
		logic fin;
		fin = it.set_end | it.column_end;
		if (col_rows < Rows) begin
			col_buf[col_rows] = it.weight_value;
			col_rows++;
			mag = it.weight_value[ValueW-1] ? 64'(17'h10000 - it.weight_value)
				: 64'(it.weight_value);
			sum = 64'(col_sq_sum) + mag * mag;
			col_sq_sum = (sum > 64'(SumSat)) ? SumSat : sum[SumW-1:0];
		end else begin
			col_dropped = 1'b1;
		end
		if (!fin) return;
		nrm = isqrt(64'(col_sq_sum));
		tot = 64'(run_total) + nrm;
		run_total = (tot > 64'(TotalSat)) ? TotalSat : tot[TotalW-1:0];
		for (int k = 0; k < col_rows; k++) begin
			mag = col_buf[k][ValueW-1] ? 64'(17'h10000 - col_buf[k]) : 64'(col_buf[k]);
			q = (nrm != 0) ? (64'(scale_reg) * mag) / nrm : 64'd0;
			if (col_buf[k][ValueW-1]) q = -q;
			r = '0;
			r.gradient = q[GradW-1:0];
			r.column_last = (k + 1 == col_rows);
			r.overflow = col_dropped;
			if (it.set_end && k + 1 == col_rows) begin
				pen = (64'(scale_reg) * 64'(run_total)) >> 16;
				r.penalty = (pen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pen[PenW-1:0];
				r.penalty_valid = 1'b1;
			end
			expected_grads.insert(expected_grads.size(), r);
		end
		if (it.set_end) run_total = '0;
		col_rows = 0;
		col_sq_sum = '0;
		col_dropped = 1'b0;
	endtask

	function automatic glcn_in_t mk(input logic [ValueW-1:0] v, input logic ce,
			input logic se);
		glcn_in_t it;
		it.weight_value = v;
		it.column_end = ce;
		it.set_end = se;
		return it;
	endfunction

	// random weight: mostly full range, some extremes and zeros
	function automatic logic [ValueW-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned rand_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 0;
			9: return $urandom_range(20, 80);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("TB_ERROR");
		$finish;
	end

	// driver: one element per transfer, random gaps between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_item <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			predict_element(in_item);
			items_sent <= items_sent + 1;
			start <= 1'b0;
			gap_left <= rand_gap();
		end else if (!start) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				in_item <= pending_items.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		glcn_out_t exp_r;
		if (arst_n && result_valid) begin
			if (expected_grads.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				fail_count++;
			end else begin
				exp_r = expected_grads.pop_front();
				grads_seen++;
				if (result.penalty_valid) penalties_seen++;
				if (result !== exp_r)
					$display("%0t: mismatch expected grad %0d last %b pen %0d pv %b ovf %b, got grad %0d last %b pen %0d pv %b ovf %b",
						$time, exp_r.gradient, exp_r.column_last, exp_r.penalty,
						exp_r.penalty_valid, exp_r.overflow, result.gradient,
						result.column_last, result.penalty, result.penalty_valid,
						result.overflow);
				if (result !== exp_r) fail_count++;
			end
		end
	end

	task automatic wait_drained();
		while (pending_items.size() != 0 || start || expected_grads.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_scale(input logic [ScaleW-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		scale_reg = v;
	endtask

	// random set: columns of mostly small lengths, occasionally long or over depth
	task automatic queue_random_set(input int unsigned cols);
		int unsigned len;
		for (int c = 0; c < cols; c++) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(Rows, Rows + 3);
				1: len = $urandom_range(10, Rows - 1);
				default: len = $urandom_range(1, 5);
			endcase
			for (int e = 0; e < len; e++) begin
				if (e + 1 < len)
					queue_item(mk(rand_weight(), 1'b0, 1'b0));
				else if (c + 1 == cols)
					queue_item(mk(rand_weight(), $urandom_range(0, 1), 1'b1));
				else
					queue_item(mk(rand_weight(), 1'b1, 1'b0));
			end
		end
	endtask

	initial begin
		logic [ScaleW-1:0] scales [4];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		col_rows = 0;
		col_sq_sum = '0;
		run_total = '0;
		col_dropped = 1'b0;
		scale_reg = '0;
		fail_count = 0;
		grads_seen = 0;
		penalties_seen = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset scale of zero, then full scale on extremes
		queue_item(mk(16'h7fff, 1'b1, 1'b0));
		queue_item(mk(16'h8000, 1'b0, 1'b1));
		wait_drained();
		write_scale(16'hffff);
		queue_item(mk(16'h0000, 1'b1, 1'b0)); // zero norm column
		queue_item(mk(16'h8000, 1'b0, 1'b0));
		queue_item(mk(16'h7fff, 1'b0, 1'b0));
		queue_item(mk(16'h0001, 1'b1, 1'b0));
		queue_item(mk(16'hffff, 1'b0, 1'b1)); // set end alone
		for (int e = 0; e < Rows + 2; e++) // over-depth column, big sums
			queue_item(mk(16'h8000, 1'b0, e == Rows + 1));
		wait_drained();

		// random sets across a spread of scale values, pausing between phases
		scales[0] = 16'h0001;
		scales[1] = 16'(($urandom & 16'hfffe) | 16'h0002);
		scales[2] = 16'h8000;
		scales[3] = 16'hffff;
		for (int p = 0; p < 4; p++) begin
			write_scale(scales[p]);
			while (items_sent < 45 + 13 * (p + 1)) begin
				queue_random_set($urandom_range(1, 3));
				wait_drained();
			end
		end
		write_scale(16'h0000);
		queue_random_set(2);
		wait_drained();

		$display("%0d elements sent, %0d gradients and %0d penalties checked",
			items_sent, grads_seen, penalties_seen);
		$display("scale values zero to full, columns from one element past buffer depth");
		if (fail_count == 0 && expected_grads.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/glcn_pkg.sv
rtl/group_lasso_column_norm_engine.sv
sim/tb.sv
